/* hw/rtl/sha_pkg.sv */
// Package for the SHA-256 message hasher: payload structs, round constants,
// initial hash values and the round/schedule helper functions. No dependencies.
package sha_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       is_last;
	} sha_in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic        word_last;
		logic        length_overflow;
	} sha_out_t;

	// One queued entry between front and back: a 32-bit message word
	// or a finish marker carrying the overflow flag in bit 0 of word.
	typedef struct packed {
		logic [31:0] word;
		logic        blk_end;
		logic        finish;
	} sha_word_t;

	typedef logic [31:0] word_t;

	localparam word_t IV [8] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	localparam word_t RK [64] = '{
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
		32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
		32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
		32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
		32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
		32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
		32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
		32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
		32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
		32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
		32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
	};

	function automatic word_t ror(input word_t x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t sg0(input word_t x);
		return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t sg1(input word_t x);
		return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t bs0(input word_t x);
		return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
	endfunction

	function automatic word_t bs1(input word_t x);
		return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
	endfunction

endpackage

/* hw/rtl/sha256_message_hasher.sv */
// SHA-256 message hasher, one byte per transfer, digest as eight words.
// A block's compression loads sixteen message words, runs 64 rounds, then adds
// into the hash values; blocks go one at a time through the single shared round unit.
// End of message adds padding (one or two blocks) then eight digest transfers.
// Reset (arst_n low) restores initial hash values and clears the count.
module sha256_message_hasher #(
	parameter int COUNT_BITS = 29
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sha_pkg::sha_in_t  in_data,
	output logic              full,
	output logic              empty,
	input  logic              pop,
	output sha_pkg::sha_out_t out_data
);
	import sha_pkg::*;

	logic      wq_push, wq_full, wq_pop, wq_empty, ready;
	sha_word_t wq_in, wq_out;

	assign full = !ready;

	sha_front #(.COUNT_BITS(COUNT_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(push), .in_item(in_data),
		.in_ready(ready), .wq_push(wq_push), .wq_data(wq_in),
		.wq_full(wq_full)
	);

	sha_wq u_wq (
		.clk(clk), .arst_n(arst_n), .push(wq_push), .wdata(wq_in),
		.full(wq_full), .pop(wq_pop), .rdata(wq_out), .empty(wq_empty)
	);

	sha_back u_back (
		.clk(clk), .arst_n(arst_n), .wq_data(wq_out), .wq_empty(wq_empty),
		.wq_pop(wq_pop), .res(out_data), .res_empty(empty),
		.res_pop(pop)
	);
endmodule

/* hw/rtl/sha_front.sv */
// Front end: packs bytes into big-endian words, counts bytes and emits
// padding and length words at end of message. Depends on sha_pkg.
module sha_front #(
	parameter int COUNT_BITS = 29
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  sha_pkg::sha_in_t   in_item,
	output logic               in_ready,
	output logic               wq_push,
	output sha_pkg::sha_word_t wq_data,
	input  logic               wq_full
);
	import sha_pkg::*;

	localparam logic [1:0] ST_BYTES = 2'd0;
	localparam logic [1:0] ST_PAD   = 2'd1;
	localparam logic [1:0] ST_FIN   = 2'd2;

	logic [1:0]            state_q;
	logic [23:0]           part_q;     // partial word, upper bytes
	logic [5:0]            fill_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  ovf_q;
	logic                  first_pad_q; // next pad word carries the 0x80 mark
	logic                  xtra_q;      // current pad block is the extra one, no length
	logic [31:0]           word_n;
	logic [31:0]           pad_word;
	logic [31:0]           bits;
	logic                  accept;

	assign in_ready = (state_q == ST_BYTES) && !wq_full;
	assign accept = in_valid && in_ready;
	assign bits = {29'(count_q), 3'b000};

	always_comb begin
		logic [1:0] k;
		k = fill_q[1:0];
		word_n = '0;
		case (k)
			2'd0: word_n = {in_item.data_byte, 24'd0};
			2'd1: word_n = {part_q[23:16], in_item.data_byte, 16'd0};
			2'd2: word_n = {part_q[23:8], in_item.data_byte, 8'd0};
			default: word_n = {part_q, in_item.data_byte};
		endcase
		// pad word: existing bytes, then 0x80 at position fill if first
		pad_word = '0;
		if (first_pad_q) begin
			case (k)
				2'd0: pad_word = 32'h8000_0000;
				2'd1: pad_word = {part_q[23:16], 24'h80_0000};
				2'd2: pad_word = {part_q[23:8], 16'h8000};
				default: pad_word = {part_q, 8'h80};
			endcase
		end
		if (fill_q[5:2] == 4'd14 && !first_pad_q) pad_word = '0;
		if (fill_q[5:2] == 4'd15 && !first_pad_q) pad_word = xtra_q ? '0 : bits;
	end

	always_comb begin
		wq_push = 1'b0;
		wq_data = '0;
		if (state_q == ST_BYTES) begin
			wq_push = accept && in_item.byte_present && (fill_q[1:0] == 2'd3);
			wq_data.word = word_n;
			wq_data.blk_end = (fill_q == 6'd63);
		end else if (state_q == ST_PAD) begin
			wq_push = !wq_full;
			wq_data.blk_end = (fill_q[5:2] == 4'd15);
			// first pad lands in the length area (slot 14 or 15): extra block
			if (first_pad_q && fill_q[5:2] >= 4'd14) wq_data.word = pad_word;
			else if (!first_pad_q && fill_q[5:2] == 4'd14) wq_data.word = '0;
			else wq_data.word = pad_word;
		end else begin
			wq_push = !wq_full;
			wq_data.word = {31'd0, ovf_q};
			wq_data.finish = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_BYTES;
			fill_q <= '0;
			count_q <= '0;
			ovf_q <= 1'b0;
			first_pad_q <= 1'b0;
			xtra_q <= 1'b0;
			part_q <= '0;
		end else begin
			case (state_q)
				ST_BYTES: begin
					if (accept) begin
						if (in_item.byte_present) begin
							part_q <= word_n[31:8];
							fill_q <= fill_q + 6'd1;
							if (&count_q) ovf_q <= 1'b1;
							else count_q <= count_q + COUNT_BITS'(1);
						end
						if (in_item.is_last) begin
							state_q <= ST_PAD;
							first_pad_q <= 1'b1;
						end
					end
				end
				ST_PAD: begin
					if (!wq_full) begin
						first_pad_q <= 1'b0;
						part_q <= '0;
						fill_q <= {fill_q[5:2] + 4'd1, 2'd0};
						if (first_pad_q && fill_q[5:2] == 4'd14) xtra_q <= 1'b1;
						else if (fill_q[5:2] == 4'd15) xtra_q <= 1'b0;
						if (fill_q[5:2] == 4'd15 && !first_pad_q && !xtra_q)
							state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!wq_full) begin
						state_q <= ST_BYTES;
						fill_q <= '0;
						count_q <= '0;
						ovf_q <= 1'b0;
					end
				end
				default: state_q <= ST_BYTES;
			endcase
		end
	end
endmodule

/* hw/rtl/sha_wq.sv */
// Short word queue between front and back ends. Depends on sha_pkg.
module sha_wq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  sha_pkg::sha_word_t wdata,
	output logic               full,
	input  logic               pop,
	output sha_pkg::sha_word_t rdata,
	output logic               empty
);
	import sha_pkg::*;

	sha_word_t  mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	assign full = cnt_q[2];
	assign empty = (cnt_q == 3'd0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) wp_q <= wp_q + 2'd1;
			if (pop && !empty) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'd0, push && !full} - {2'd0, pop && !empty};
		end
	end
endmodule

/* hw/rtl/sha_back.sv */
// Back end: schedules words and runs one compression round per cycle,
// then streams the digest. Depends on sha_pkg.
module sha_back (
	input  logic               clk,
	input  logic               arst_n,
	input  sha_pkg::sha_word_t wq_data,
	input  logic               wq_empty,
	output logic               wq_pop,
	output sha_pkg::sha_out_t  res,
	output logic               res_empty,
	input  logic               res_pop
);
	import sha_pkg::*;

	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_ADD  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0] state_q;
	word_t      h_q [8];
	word_t      v_q [8];
	word_t      w_q [16];    // rolling schedule window
	logic [5:0] rnd_q;
	logic [3:0] widx_q;
	logic [2:0] oidx_q;
	logic       ovf_q;
	word_t      wcur, wnew, t1, t2;

	assign wcur = (rnd_q < 6'd16) ? w_q[rnd_q[3:0]] : wnew;
	assign wnew = w_q[0] + sg0(w_q[1]) + w_q[9] + sg1(w_q[14]);
	assign t1 = v_q[7] + bs1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ RK[rnd_q] + wcur;
	assign t2 = bs0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	assign wq_pop = (state_q == ST_LOAD) && !wq_empty;
	assign res_empty = (state_q != ST_OUT);
	assign res.digest_word = h_q[oidx_q];
	assign res.word_last = (oidx_q == 3'd7);
	assign res.length_overflow = ovf_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && !wq_empty && !wq_data.finish)
			w_q[widx_q] <= wq_data.word;
		if (state_q == ST_RUN && rnd_q >= 6'd16) begin
			// shift window once the first sixteen words have been used
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wnew;
		end
		if (state_q == ST_RUN) begin
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end else if (state_q == ST_LOAD) begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			for (int i = 0; i < 8; i++) h_q[i] <= IV[i];
			rnd_q <= '0;
			widx_q <= '0;
			oidx_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (!wq_empty) begin
						if (wq_data.finish) begin
							state_q <= ST_OUT;
							ovf_q <= wq_data.word[0];
							oidx_q <= '0;
						end else begin
							widx_q <= widx_q + 4'd1;
							if (wq_data.blk_end) begin
								state_q <= ST_RUN;
								rnd_q <= '0;
							end
						end
					end
				end
				ST_RUN: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= ST_ADD;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					widx_q <= '0;
					state_q <= ST_LOAD;
				end
				ST_OUT: begin
					if (res_pop) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							state_q <= ST_LOAD;
							for (int i = 0; i < 8; i++) h_q[i] <= IV[i];
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end
endmodule
